### rtl/core/bssa_pkg.sv
package bssa_pkg;

	localparam int DEF_SLOTS_PER_SLAB = 256;
	localparam int DEF_MAX_SLABS = 16;

	localparam int WORD_BITS = 32;
	localparam int BITMAP_WORDS = 128;
	localparam int WORD_AW = 7;
	localparam int BIT_AW = 5;
	localparam int SLOT_W = 12;
	localparam int CNT_W = 13;
	localparam int BITMAP_SLOTS = 4096;

	localparam logic [2:0] OP_ALLOC = 3'd0;
	localparam logic [2:0] OP_CLAIM = 3'd1;
	localparam logic [2:0] OP_QUERY = 3'd2;
	localparam logic [2:0] OP_RELEASE = 3'd3;
	localparam logic [2:0] OP_COUNT = 3'd4;
	localparam logic [2:0] OP_CLEAR = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_NOT_USED = 2'd3;

	typedef struct packed {
		logic                 en;
		logic [WORD_AW-1:0]   addr;
		logic [WORD_BITS-1:0] data;
	} bm_wr_t;

endpackage

### rtl/core/bssa_bitmap_ram.sv
module bssa_bitmap_ram (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic [bssa_pkg::WORD_AW-1:0]   rd_addr,
	input  bssa_pkg::bm_wr_t              wr,
	output logic [bssa_pkg::WORD_BITS-1:0] rd_data
);
	import bssa_pkg::*;

	logic [WORD_BITS-1:0]    mem [BITMAP_WORDS];
	logic [BITMAP_WORDS-1:0] vld_q;
	logic [WORD_BITS-1:0]    rd_word_q;
	logic                    rd_vld_q;

	// A word whose valid bit is clear reads as all free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clear) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[rd_addr] & ~clear;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_word_q <= mem[rd_addr];
	end

	assign rd_data = rd_vld_q ? rd_word_q : '0;

endmodule

### rtl/core/bitmap_slab_slot_allocator_top.sv
// Channel  Direction  Fields (lowest bit first)
// s_axis   in         tuser: op[2:0]; tdata: slot_index[11:0]
// m_axis   out        tdata: result_index[11:0], was_used[12], status[14:13],
//                     used_total[27:15]
//
// One operation is in flight at a time; the input is ready only while the control is idle.
// Count and clear go from idle to output; query and release pass a read state first, and
// claim also an open state per slab it opens. Allocate reads one bitmap word at a time
// from the single memory read port, newest slab first, plus a state to open a new slab.
// Reset and clear drop per-word valid bits at once, so no clearing pass is needed.
// A stalled result waits in the output register while the next operation is accepted.
module bitmap_slab_slot_allocator_top #(
	parameter int SLOTS_PER_SLAB = bssa_pkg::DEF_SLOTS_PER_SLAB,
	parameter int MAX_SLABS = bssa_pkg::DEF_MAX_SLABS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // slot_index[11:0]
	input  logic [2:0]  s_axis_tuser,  // op[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // result_index, was_used, status, used_total
);
	import bssa_pkg::*;

	localparam int USL = (MAX_SLABS * SLOTS_PER_SLAB > BITMAP_SLOTS) ?
		BITMAP_SLOTS / SLOTS_PER_SLAB : MAX_SLABS;
	localparam int OW = $clog2(MAX_SLABS + 1);
	localparam logic [CNT_W-1:0] SPS = CNT_W'(SLOTS_PER_SLAB);
	localparam logic [SLOT_W-1:0] SPS_S = SLOT_W'(SLOTS_PER_SLAB);
	localparam logic [CNT_W-1:0] RANGE = CNT_W'(USL * SLOTS_PER_SLAB);
	localparam logic [OW-1:0] USL_V = OW'(USL);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_NEW = 3'd3;
	localparam logic [2:0] S_OPEN = 3'd4;
	localparam logic [2:0] S_OUT = 3'd5;

	logic [2:0]          state_q;
	logic [2:0]          op_q;
	logic [SLOT_W-1:0]   idx_q;
	logic [OW-1:0]       open_q;
	logic [CNT_W-1:0]    open_end_q;
	logic [CNT_W-1:0]    used_q;
	logic [SLOT_W-1:0]   base_q;
	logic [SLOT_W-1:0]   end_q;
	logic [WORD_AW-1:0]  word_q;
	logic [SLOT_W-1:0]   res_idx_q;
	logic                was_q;
	logic [1:0]          status_q;
	logic                m_valid_q;
	logic [31:0]         m_data_q;

	logic                s_fire;
	logic [2:0]          in_op;
	logic [SLOT_W-1:0]   in_idx;
	logic [CNT_W-1:0]    last_base;
	logic [SLOT_W-1:0]   prev_base;
	logic [WORD_AW-1:0]  rd_addr;
	logic [WORD_BITS-1:0] rd_data;
	logic                mem_clear;
	bm_wr_t              wr;
	logic [WORD_BITS-1:0] lo_mask;
	logic [WORD_BITS-1:0] hi_mask;
	logic [WORD_BITS-1:0] free_bits;
	logic [BIT_AW-1:0]   free_pos;
	logic                rd_bit;
	logic                out_load;

	assign in_op = s_axis_tuser;
	assign in_idx = s_axis_tdata[SLOT_W-1:0];
	assign s_axis_tready = (state_q == S_IDLE);
	assign s_fire = s_axis_tvalid & s_axis_tready;
	assign last_base = open_end_q - SPS;
	assign prev_base = base_q - SPS_S;
	assign rd_bit = rd_data[idx_q[BIT_AW-1:0]];
	assign out_load = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);
	assign mem_clear = s_fire && (in_op == OP_CLEAR);

	always_comb begin
		lo_mask = (word_q == base_q[SLOT_W-1:BIT_AW]) ?
			({WORD_BITS{1'b1}} << base_q[BIT_AW-1:0]) : {WORD_BITS{1'b1}};
		hi_mask = (word_q == end_q[SLOT_W-1:BIT_AW]) ?
			({WORD_BITS{1'b1}} >> (5'd31 - end_q[BIT_AW-1:0])) : {WORD_BITS{1'b1}};
		free_bits = ~rd_data & lo_mask & hi_mask;
		free_pos = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				free_pos = BIT_AW'(i);
			end
		end
	end

	always_comb begin
		rd_addr = word_q;
		wr = '0;
		priority case (state_q)
			S_IDLE: begin
				if (in_op == OP_ALLOC) begin
					rd_addr = last_base[SLOT_W-1:BIT_AW];
				end else begin
					rd_addr = in_idx[SLOT_W-1:BIT_AW];
				end
			end
			S_RD: begin
				wr.addr = idx_q[SLOT_W-1:BIT_AW];
				if (op_q == OP_CLAIM && !rd_bit) begin
					wr.en = 1'b1;
					wr.data = rd_data | (WORD_BITS'(1) << idx_q[BIT_AW-1:0]);
				end else if (op_q == OP_RELEASE && rd_bit) begin
					wr.en = 1'b1;
					wr.data = rd_data & ~(WORD_BITS'(1) << idx_q[BIT_AW-1:0]);
				end
			end
			S_SCAN: begin
				wr.addr = word_q;
				wr.data = rd_data | (WORD_BITS'(1) << free_pos);
				if (|free_bits) begin
					wr.en = 1'b1;
				end else if (word_q != end_q[SLOT_W-1:BIT_AW]) begin
					rd_addr = word_q + 1'b1;
				end else if (base_q != '0) begin
					rd_addr = prev_base[SLOT_W-1:BIT_AW];
				end else begin
					rd_addr = open_end_q[SLOT_W-1:BIT_AW];
				end
			end
			S_NEW: begin
				wr.en = 1'b1;
				wr.addr = open_end_q[SLOT_W-1:BIT_AW];
				wr.data = rd_data | (WORD_BITS'(1) << open_end_q[BIT_AW-1:0]);
			end
			default: begin
			end
		endcase
	end

	bssa_bitmap_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (mem_clear),
		.rd_addr(rd_addr),
		.wr     (wr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			open_q <= '0;
			open_end_q <= '0;
			used_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_fire) begin
						priority case (in_op)
							OP_ALLOC: state_q <= (open_q == '0) ? S_NEW : S_SCAN;
							OP_CLAIM, OP_QUERY, OP_RELEASE: begin
								state_q <= ({1'b0, in_idx} >= RANGE) ? S_OUT : S_RD;
							end
							OP_CLEAR: begin
								open_q <= '0;
								open_end_q <= '0;
								used_q <= '0;
								state_q <= S_OUT;
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_RD: begin
					state_q <= S_OUT;
					if (op_q == OP_CLAIM) begin
						if (!rd_bit) begin
							used_q <= used_q + 1'b1;
						end
						if (open_end_q <= {1'b0, idx_q}) begin
							state_q <= S_OPEN;
						end
					end else if (op_q == OP_RELEASE && rd_bit) begin
						used_q <= used_q - 1'b1;
					end
				end
				S_OPEN: begin
					open_q <= open_q + 1'b1;
					open_end_q <= open_end_q + SPS;
					if (open_end_q + SPS > {1'b0, idx_q}) begin
						state_q <= S_OUT;
					end
				end
				S_SCAN: begin
					if (|free_bits) begin
						used_q <= used_q + 1'b1;
						state_q <= S_OUT;
					end else if (word_q == end_q[SLOT_W-1:BIT_AW] && base_q == '0) begin
						state_q <= (open_q < USL_V) ? S_NEW : S_OUT;
					end
				end
				S_NEW: begin
					used_q <= used_q + 1'b1;
					open_q <= open_q + 1'b1;
					open_end_q <= open_end_q + SPS;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		priority case (state_q)
			S_IDLE: begin
				if (s_fire) begin
					op_q <= in_op;
					idx_q <= in_idx;
					res_idx_q <= in_idx;
					was_q <= 1'b0;
					status_q <= ST_OK;
					base_q <= last_base[SLOT_W-1:0];
					end_q <= SLOT_W'(open_end_q - 1'b1);
					word_q <= last_base[SLOT_W-1:BIT_AW];
					if ((in_op == OP_CLAIM || in_op == OP_QUERY || in_op == OP_RELEASE)
							&& {1'b0, in_idx} >= RANGE) begin
						status_q <= ST_RANGE;
					end
					if (in_op == OP_ALLOC) begin
						res_idx_q <= '0;
					end
				end
			end
			S_RD: begin
				was_q <= rd_bit;
				if (op_q == OP_RELEASE && !rd_bit) begin
					status_q <= ST_NOT_USED;
				end
			end
			S_SCAN: begin
				if (|free_bits) begin
					res_idx_q <= {word_q, free_pos};
				end else if (word_q != end_q[SLOT_W-1:BIT_AW]) begin
					word_q <= word_q + 1'b1;
				end else if (base_q != '0) begin
					base_q <= prev_base;
					end_q <= base_q - 1'b1;
					word_q <= prev_base[SLOT_W-1:BIT_AW];
				end else if (open_q >= USL_V) begin
					status_q <= ST_FULL;
				end
			end
			S_NEW: begin
				res_idx_q <= open_end_q[SLOT_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {4'b0000, used_q, status_q, was_q, res_idx_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= RANGE)
		else $error("used count exceeds the usable range");

	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= USL_V)
		else $error("open slab count exceeds the usable slab count");

	a_scan_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> word_q >= base_q[SLOT_W-1:BIT_AW] &&
			word_q <= end_q[SLOT_W-1:BIT_AW])
		else $error("scan word left the slab window");

	a_full_means_all_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && status_q == ST_FULL |-> open_q == USL_V && op_q == OP_ALLOC)
		else $error("no free slot reported while a slab could still be opened");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> state_q != S_IDLE)
		else $error("accepted transfer left the control idle");

endmodule
